// ===== sv/hexni_pkg.sv =====
// Shared types and fixed field widths of the hex element node indexer.
package hexni_pkg;

  localparam int ELEM_W   = 10;
  localparam int DIM_W    = 11;
  localparam int GCOUNT_W = 36;
  localparam int CORNER_W = 31;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_GLOBAL = 2'd1,
    ST_LOCAL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [DIM_W-1:0]    nodes_x;
    logic [DIM_W-1:0]    nodes_y;
    logic [DIM_W-1:0]    nodes_z;
    logic                off_i;
    logic                off_j;
    logic                off_k;
    logic [GCOUNT_W-1:0] gcount;
  } cfg_t;

endpackage

// ===== sv/hexni_if.sv =====
// Request and result channel interfaces of the hex element node indexer.
interface hexni_in_if import hexni_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] elem_i;
  logic [ELEM_W-1:0] elem_j;
  logic [ELEM_W-1:0] elem_k;

  modport source (output valid, elem_i, elem_j, elem_k, input ready);
  modport sink (input valid, elem_i, elem_j, elem_k, output ready);
endinterface

interface hexni_out_if import hexni_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CORNER_W-1:0] corner_0;
  logic [CORNER_W-1:0] corner_1;
  logic [CORNER_W-1:0] corner_2;
  logic [CORNER_W-1:0] corner_3;
  logic [CORNER_W-1:0] corner_4;
  logic [CORNER_W-1:0] corner_5;
  logic [CORNER_W-1:0] corner_6;
  logic [CORNER_W-1:0] corner_7;
  status_t             status;

  modport source (output valid, corner_0, corner_1, corner_2, corner_3, corner_4, corner_5,
                  corner_6, corner_7, status, input ready);
  modport sink (input valid, corner_0, corner_1, corner_2, corner_3, corner_4, corner_5,
                corner_6, corner_7, status, output ready);
endinterface

// ===== sv/hexni_pipe.sv =====
// Five-stage datapath that turns element coordinates into eight checked corner indices.
module hexni_pipe import hexni_pkg::*; #(
  parameter int MAX_NODES_PER_AXIS = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  hexni_in_if.sink      in_ch,
  hexni_out_if.source   out_ch
);

  localparam int CW_RAW  = $clog2(MAX_NODES_PER_AXIS + 1);
  localparam int CW      = (CW_RAW < DIM_W) ? CW_RAW : DIM_W;
  localparam int CRD_W   = ELEM_W + 1;
  localparam int PLANE_W = 2 * CW;
  localparam int LOCAL_W = 3 * CW;
  localparam int JX_W    = CRD_W + CW;
  localparam int KP_W    = CRD_W + PLANE_W;
  localparam int NODE_W  = CRD_W + PLANE_W + 1;
  localparam int CMP_A   = (NODE_W > GCOUNT_W) ? NODE_W : GCOUNT_W;
  localparam int CMP_W   = (CMP_A > LOCAL_W) ? CMP_A : LOCAL_W;

  // Clamped grid dimensions and the derived plane and volume sizes.
  logic [CW-1:0]      x_c, y_c, z_c;
  logic [PLANE_W-1:0] plane_r;
  logic [LOCAL_W-1:0] local_r;

  always_comb begin
    x_c = (32'(cfg.nodes_x) > 32'(MAX_NODES_PER_AXIS)) ? CW'(MAX_NODES_PER_AXIS)
                                                       : CW'(cfg.nodes_x);
    y_c = (32'(cfg.nodes_y) > 32'(MAX_NODES_PER_AXIS)) ? CW'(MAX_NODES_PER_AXIS)
                                                       : CW'(cfg.nodes_y);
    z_c = (32'(cfg.nodes_z) > 32'(MAX_NODES_PER_AXIS)) ? CW'(MAX_NODES_PER_AXIS)
                                                       : CW'(cfg.nodes_z);
  end

  // The plane size is registered from the clamped dimensions and the volume from
  // the plane size; each stage that reads one is at least as many registers deep.
  always_ff @(posedge clk) begin
    plane_r <= PLANE_W'(x_c) * PLANE_W'(y_c);
    local_r <= LOCAL_W'(plane_r) * LOCAL_W'(z_c);
  end

  // Per-stage advance: a stage loads when it is empty or its successor moves.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic adv1, adv2, adv3, adv4, adv5;

  assign adv5        = !v5_r || out_ch.ready;
  assign adv4        = !v4_r || adv5;
  assign adv3        = !v3_r || adv4;
  assign adv2        = !v2_r || adv3;
  assign adv1        = !v1_r || adv2;
  assign in_ch.ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_ch.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= v4_r;
    end
  end

  // Stage 1: ghost offsets applied.
  logic [CRD_W-1:0] i1_r, j1_r, k1_r;

  always_ff @(posedge clk) begin
    if (adv1) begin
      i1_r <= CRD_W'(in_ch.elem_i) + CRD_W'(cfg.off_i);
      j1_r <= CRD_W'(in_ch.elem_j) + CRD_W'(cfg.off_j);
      k1_r <= CRD_W'(in_ch.elem_k) + CRD_W'(cfg.off_k);
    end
  end

  // Stage 2: row offset j*X.
  logic [CRD_W-1:0] i2_r, k2_r;
  logic [JX_W-1:0]  jx2_r;
  logic [JX_W-1:0]  jx2_nxt;

  assign jx2_nxt = JX_W'(j1_r) * JX_W'(x_c);

  always_ff @(posedge clk) begin
    if (adv2) begin
      i2_r  <= i1_r;
      k2_r  <= k1_r;
      jx2_r <= jx2_nxt;
    end
  end

  // Stage 3: plane offset k*X*Y and the two row bases.
  logic [KP_W-1:0]   kp3_r, kp3_nxt;
  logic [NODE_W-1:0] row0_3_r, row1_3_r, row0_3_nxt, row1_3_nxt;

  assign kp3_nxt    = KP_W'(k2_r) * KP_W'(plane_r);
  assign row0_3_nxt = NODE_W'(i2_r) + NODE_W'(jx2_r);
  assign row1_3_nxt = NODE_W'(i2_r) + NODE_W'(jx2_r) + NODE_W'(x_c);

  always_ff @(posedge clk) begin
    if (adv3) begin
      kp3_r    <= kp3_nxt;
      row0_3_r <= row0_3_nxt;
      row1_3_r <= row1_3_nxt;
    end
  end

  // Stage 4: the eight corner indices at full width.
  logic [NODE_W-1:0] node4_r   [8];
  logic [NODE_W-1:0] node4_nxt [8];
  logic [NODE_W-1:0] kp_lo, kp_hi;

  always_comb begin
    kp_lo = NODE_W'(kp3_r);
    kp_hi = NODE_W'(kp3_r) + NODE_W'(plane_r);
    for (int n = 0; n < 8; n++) begin
      node4_nxt[n] = (n[1] ? row1_3_r : row0_3_r) + (n[2] ? kp_hi : kp_lo)
                     + NODE_W'(n[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      for (int n = 0; n < 8; n++) begin
        node4_r[n] <= node4_nxt[n];
      end
    end
  end

  // Stage 5: bound checks; the first failing corner decides the status.
  logic [CORNER_W-1:0] corner5_r [8];
  status_t             status5_r, status5_nxt;
  logic [7:0]          fail_g, fail_l;

  always_comb begin
    status5_nxt = ST_OK;
    for (int n = 0; n < 8; n++) begin
      fail_g[n] = CMP_W'(node4_r[n]) >= CMP_W'(cfg.gcount);
      fail_l[n] = CMP_W'(node4_r[n]) >= CMP_W'(local_r);
    end
    for (int n = 7; n >= 0; n--) begin
      if (fail_g[n]) begin
        status5_nxt = ST_GLOBAL;
      end else if (fail_l[n]) begin
        status5_nxt = ST_LOCAL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      status5_r <= status5_nxt;
      for (int n = 0; n < 8; n++) begin
        corner5_r[n] <= CORNER_W'(node4_r[n]);
      end
    end
  end

  assign out_ch.valid    = v5_r;
  assign out_ch.status   = status5_r;
  assign out_ch.corner_0 = corner5_r[0];
  assign out_ch.corner_1 = corner5_r[1];
  assign out_ch.corner_2 = corner5_r[2];
  assign out_ch.corner_3 = corner5_r[3];
  assign out_ch.corner_4 = corner5_r[4];
  assign out_ch.corner_5 = corner5_r[5];
  assign out_ch.corner_6 = corner5_r[6];
  assign out_ch.corner_7 = corner5_r[7];

endmodule

// ===== sv/hex_element_node_indexer_top.sv =====
// Top level of the hex element node indexer: register file and datapath.
//
// A request on in_ch carries the local element coordinates (elem_i, elem_j,
// elem_k). The block answers with one result on out_ch: the eight corner node
// indices of the hexahedron, i fastest, then j, then k, and a status that
// tells whether the first failing corner exceeds the global or the local count.
// The grid dimensions, ghost offsets and global node count are written over
// the APB-style cfg_ port; each register sits at byte address 8*index, and
// writes are expected only while no request is in flight.
// One request is accepted every cycle while in_ch.ready is high; the five
// register stages are the ghost offset add, the two multiplies (row and
// plane offsets), the corner sums and the bound compare.
// A synchronous low rst_n empties the pipeline and restores the register
// reset values. When out_ch is stalled the stages fill one by one; in_ch
// drops ready only once all five stages hold a result, and nothing is lost.
module hex_element_node_indexer_top import hexni_pkg::*; #(
  parameter int MAX_NODES_PER_AXIS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  hexni_in_if.sink    in_ch,
  hexni_out_if.source out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [2:0] {
    REG_NODES_X = 3'd0,
    REG_NODES_Y = 3'd1,
    REG_NODES_Z = 3'd2,
    REG_OFF_I   = 3'd3,
    REG_OFF_J   = 3'd4,
    REG_OFF_K   = 3'd5,
    REG_GCOUNT  = 3'd6
  } reg_idx_t;

  cfg_t       cfg_r;
  logic       cfg_wr;
  logic [2:0] reg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nodes_x <= DIM_W'(2);
      cfg_r.nodes_y <= DIM_W'(2);
      cfg_r.nodes_z <= DIM_W'(2);
      cfg_r.off_i   <= 1'b0;
      cfg_r.off_j   <= 1'b0;
      cfg_r.off_k   <= 1'b0;
      cfg_r.gcount  <= GCOUNT_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_NODES_X: cfg_r.nodes_x <= cfg_pwdata[DIM_W-1:0];
        REG_NODES_Y: cfg_r.nodes_y <= cfg_pwdata[DIM_W-1:0];
        REG_NODES_Z: cfg_r.nodes_z <= cfg_pwdata[DIM_W-1:0];
        REG_OFF_I:   cfg_r.off_i   <= cfg_pwdata[0];
        REG_OFF_J:   cfg_r.off_j   <= cfg_pwdata[0];
        REG_OFF_K:   cfg_r.off_k   <= cfg_pwdata[0];
        REG_GCOUNT:  cfg_r.gcount  <= cfg_pwdata[GCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_NODES_X: cfg_prdata = 64'(cfg_r.nodes_x);
      REG_NODES_Y: cfg_prdata = 64'(cfg_r.nodes_y);
      REG_NODES_Z: cfg_prdata = 64'(cfg_r.nodes_z);
      REG_OFF_I:   cfg_prdata = 64'(cfg_r.off_i);
      REG_OFF_J:   cfg_prdata = 64'(cfg_r.off_j);
      REG_OFF_K:   cfg_prdata = 64'(cfg_r.off_k);
      REG_GCOUNT:  cfg_prdata = 64'(cfg_r.gcount);
      default:     cfg_prdata = 64'd0;
    endcase
  end

  hexni_pipe #(
    .MAX_NODES_PER_AXIS (MAX_NODES_PER_AXIS)
  ) u_pipe (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

`ifndef ASSERT_OFF
  // Reset empties every stage, so no result is offered in the cycle after it.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result offered right after reset");

  // Corner 1 is corner 0 moved one node along x.
  a_corner_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.corner_1 == out_ch.corner_0 + CORNER_W'(1))
    else $error("corner 1 is not corner 0 plus one");

  // Requests are refused only when the whole pipeline is backed up.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("request refused while the pipeline can move");
`endif

endmodule
